### hw/rtl/gamepad_cursor_controller_macros.svh
// assertion helpers for the cursor controller
`ifndef GAMEPAD_CURSOR_CONTROLLER_MACROS_SVH
`define GAMEPAD_CURSOR_CONTROLLER_MACROS_SVH

// implication checked on every clock edge outside reset
`define GCC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gcc check failed");

// next-cycle implication checked outside reset
`define GCC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gcc check failed");

`endif

### hw/rtl/gcc_pkg.sv
// ----------------------------------------------------------------------------
// gcc_pkg
// shared types and constants of the gamepad cursor controller
// ----------------------------------------------------------------------------
package gcc_pkg;

  typedef struct packed {
    logic       connected;
    logic       read_ok;
    logic [7:0] pad_mode;
    logic [15:0] buttons_raw;
    logic [7:0] left_stick_x;
    logic [7:0] left_stick_y;
    logic [7:0] right_stick_x;
    logic [7:0] right_stick_y;
  } poll_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [15:0]       held_mask;
    logic [15:0]       pressed_mask;
    logic [15:0]       released_mask;
    logic signed [7:0] axis_left_x;
    logic signed [7:0] axis_left_y;
    logic signed [7:0] axis_right_x;
    logic signed [7:0] axis_right_y;
    logic [9:0]        cursor_x;
    logic [9:0]        cursor_y;
    logic              moved;
    logic              calibrated;
  } result_t;

  typedef enum logic [1:0] {
    ST_DISCONNECTED = 2'd0,
    ST_IGNORED      = 2'd1,
    ST_PROCESSED    = 2'd2
  } status_t;

  // classified poll passed from front to back
  typedef struct packed {
    status_t           kind;
    logic [15:0]       held;
    logic [15:0]       pressed;
    logic [15:0]       released;
    logic signed [7:0] ax0;
    logic signed [7:0] ax1;
    logic signed [7:0] ax2;
    logic signed [7:0] ax3;
    logic              calibrated;
  } work_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_MUL1, BK_MUL2, BK_DIV, BK_FIX, BK_MOVE, BK_OUT
  } bk_state_t;

  localparam logic [2:0] REG_WIDTH  = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_DEAD   = 3'd2;
  localparam logic [2:0] REG_STEPX  = 3'd3;
  localparam logic [2:0] REG_STEPY  = 3'd4;

  localparam int BTN_UP    = 4;
  localparam int BTN_RIGHT = 5;
  localparam int BTN_DOWN  = 6;
  localparam int BTN_LEFT  = 7;

  localparam logic [7:0] WIN_LO = 8'd96;
  localparam logic [7:0] WIN_HI = 8'd160;

  function automatic logic in_window(input logic [7:0] v);
    return (v >= WIN_LO) && (v <= WIN_HI);
  endfunction

endpackage

### hw/rtl/gcc_front.sv
// ----------------------------------------------------------------------------
// gcc_front
// classifies polls, calibrates centres, derives masks and conditioned axes
// ----------------------------------------------------------------------------
module gcc_front
  import gcc_pkg::*;
#(
  parameter int CALIB_SAMPLES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  poll_t       in_poll,
  output logic        in_ready,
  input  logic [6:0]  deadzone,
  output logic        out_valid,
  output work_t       out_work,
  input  logic        out_ready
);

  localparam int CW = $clog2(CALIB_SAMPLES + 1);
  localparam int SW = 8 + $clog2(CALIB_SAMPLES + 1);

  logic [15:0]   previous_held;
  logic          centre_done;
  logic [CW-1:0] sample_count;
  logic [SW-1:0] axis_sums [4];
  logic [7:0]    axis_centres [4];

  logic [7:0] raw [4];
  logic [SW-1:0] add [4];
  logic [SW-1:0] sums_next [4];
  logic [7:0] cen [4];
  logic signed [7:0] ax [4];
  logic take, sample, finish;
  logic [15:0] held;
  work_t w;

  assign raw[0] = in_poll.left_stick_x;
  assign raw[1] = in_poll.left_stick_y;
  assign raw[2] = in_poll.right_stick_x;
  assign raw[3] = in_poll.right_stick_y;

  assign in_ready = !out_valid || out_ready;
  assign take = in_valid && in_ready;

  function automatic logic signed [7:0] cond(input logic [7:0] v, input logic [7:0] c,
                                             input logic [6:0] dz);
    logic signed [8:0] d;
    logic [8:0] m;
    d = $signed({1'b0, v}) - $signed({1'b0, c});
    m = d[8] ? 9'(-d) : 9'(d);
    if (m < {2'b00, dz}) return 8'sd0;
    if (d > 9'sd127) return 8'sd127;
    if (d < -9'sd127) return -8'sd127;
    return d[7:0];
  endfunction

  always_comb begin
    sample = !centre_done && in_window(raw[0]) && in_window(raw[1]);
    finish = sample && (32'(sample_count) + 1 >= CALIB_SAMPLES);
    for (int i = 0; i < 4; i++) begin
      add[i] = (i < 2 || in_window(raw[i])) ? SW'(raw[i]) : SW'(8'd128);
      sums_next[i] = axis_sums[i] + add[i];
      cen[i] = finish ? 8'(sums_next[i] / CALIB_SAMPLES) : axis_centres[i];
      ax[i] = cond(raw[i], cen[i], deadzone);
    end
    held = ~in_poll.buttons_raw;
    w = '0;
    w.calibrated = centre_done;
    if (!in_poll.connected) begin
      w.kind = ST_DISCONNECTED;
    end else if (!in_poll.read_ok || in_poll.pad_mode == 8'd0 ||
                 in_poll.buttons_raw == 16'd0) begin
      w.kind = ST_IGNORED;
      w.held = previous_held;
    end else begin
      w.kind = ST_PROCESSED;
      w.held = held;
      w.pressed = held & ~previous_held;
      w.released = previous_held & ~held;
      w.calibrated = centre_done || finish;
      if (w.calibrated) begin
        w.ax0 = ax[0]; w.ax1 = ax[1]; w.ax2 = ax[2]; w.ax3 = ax[3];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      previous_held <= '0;
      centre_done <= 1'b0;
      sample_count <= '0;
      for (int i = 0; i < 4; i++) begin
        axis_sums[i] <= '0;
        axis_centres[i] <= 8'd128;
      end
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (take) begin
        out_valid <= 1'b1;
        out_work <= w;
        if (w.kind == ST_DISCONNECTED) previous_held <= '0;
        if (w.kind == ST_PROCESSED) begin
          previous_held <= held;
          if (sample) begin
            sample_count <= sample_count + 1'b1;
            for (int i = 0; i < 4; i++) begin
              axis_sums[i] <= sums_next[i];
              axis_centres[i] <= cen[i];
            end
            if (finish) centre_done <= 1'b1;
          end
        end
      end
    end
  end

  `include "gamepad_cursor_controller_macros.svh"
  `GCC_ASSERT_IMPL(a_calib_sticky, centre_done, sample_count >= CW'(CALIB_SAMPLES))
  `GCC_ASSERT_NEXT(a_hold_stall, out_valid && !out_ready, out_valid && $stable(out_work))
  `GCC_ASSERT_IMPL(a_no_calib_axes, out_valid && !out_work.calibrated, out_work.ax0 == 8'sd0)

endmodule

### hw/rtl/gcc_back.sv
// ----------------------------------------------------------------------------
// gcc_back
// squared stick response, d-pad steps and cursor integration
// ----------------------------------------------------------------------------
module gcc_back
  import gcc_pkg::*;
#(
  parameter int POS_FRAC_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  work_t       in_work,
  output logic        in_ready,
  input  logic [10:0] screen_width,
  input  logic [10:0] screen_height,
  input  logic [11:0] step_x,
  input  logic [11:0] step_y,
  output logic        out_valid,
  output result_t     out_result,
  input  logic        out_ready
);

  localparam int PW = 10 + POS_FRAC_BITS;
  localparam int SH = (POS_FRAC_BITS >= 8) ? POS_FRAC_BITS - 8 : 0;
  localparam int SR = (POS_FRAC_BITS >= 8) ? 0 : 8 - POS_FRAC_BITS;
  localparam int NW = 26 + SH;
  localparam int RW = NW - 13;
  localparam int EW = NW + 1;
  localparam int DW = PW + 4;
  localparam int Den = 16129 << SR;
  // floor(2^NW / Den): the product estimate is exact or one low
  localparam longint RECIP = (longint'(1) << NW) / Den;

  bk_state_t state, state_next;
  work_t wk;
  logic [PW-1:0] pos_x, pos_y;
  logic [13:0] sq_x, sq_y;
  logic [NW-1:0] num_x, num_y;
  logic [RW-1:0] q_x, q_y;
  logic fix_x, fix_y;
  logic signed [DW-1:0] dx, dy;
  logic signed [DW-1:0] nx, ny;
  logic [PW-1:0] hx, hy;
  logic [PW-1:0] cx, cy;
  logic [6:0] mx, my;
  logic mv;

  function automatic logic [DW-1:0] step_pos(input logic [11:0] s);
    logic [DW+11:0] t;
    t = (DW+12)'(s) << SH;
    return DW'(t >> SR);
  endfunction

  function automatic logic [PW-1:0] hi_pos(input logic [10:0] s);
    logic [10:0] c;
    logic [PW-1:0] h;
    c = (s == 11'd0) ? 11'd1 : (s > 11'd1024 ? 11'd1024 : s);
    h = PW'(c - 11'd1);
    return h << POS_FRAC_BITS;
  endfunction

  function automatic logic [PW-1:0] clampp(input logic signed [DW-1:0] p,
                                          input logic [PW-1:0] hi);
    if (p < 0) return '0;
    if (p > $signed({2'b00, hi})) return hi;
    return PW'(p);
  endfunction

  assign mx = wk.ax0[7] ? 7'(-wk.ax0) : wk.ax0[6:0];
  assign my = wk.ax1[7] ? 7'(-wk.ax1) : wk.ax1[6:0];
  assign in_ready = (state == BK_IDLE);
  assign hx = hi_pos(screen_width);
  assign hy = hi_pos(screen_height);

  always_comb begin
    // quotient one low when another whole divisor still fits the numerator
    fix_x = (EW'(q_x) * EW'(Den) + EW'(Den)) <= EW'(num_x);
    fix_y = (EW'(q_y) * EW'(Den) + EW'(Den)) <= EW'(num_y);
    dx = wk.ax0[7] ? -$signed(DW'(q_x)) : $signed(DW'(q_x));
    dy = wk.ax1[7] ? -$signed(DW'(q_y)) : $signed(DW'(q_y));
    if (wk.held[BTN_LEFT])  dx = dx - $signed(step_pos(step_x));
    if (wk.held[BTN_RIGHT]) dx = dx + $signed(step_pos(step_x));
    if (wk.held[BTN_UP])    dy = dy - $signed(step_pos(step_y));
    if (wk.held[BTN_DOWN])  dy = dy + $signed(step_pos(step_y));
    nx = $signed({4'b0, pos_x}) + dx;
    ny = $signed({4'b0, pos_y}) + dy;
    cx = clampp(nx, hx);
    cy = clampp(ny, hy);
    state_next = state;
    unique case (state)
      BK_IDLE: if (in_valid) state_next = (in_work.kind == ST_PROCESSED) ? BK_MUL1 : BK_OUT;
      BK_MUL1: state_next = BK_MUL2;
      BK_MUL2: state_next = BK_DIV;
      BK_DIV:  state_next = BK_FIX;
      BK_FIX:  state_next = BK_MOVE;
      BK_MOVE: state_next = BK_OUT;
      BK_OUT:  if (!out_valid || out_ready) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      out_valid <= 1'b0;
      pos_x <= PW'(320) << POS_FRAC_BITS;
      pos_y <= PW'(224) << POS_FRAC_BITS;
    end else begin
      state <= state_next;
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        BK_IDLE: if (in_valid) begin
          wk <= in_work;
          mv <= 1'b0;
        end
        BK_MUL1: begin
          sq_x <= 14'(mx) * 14'(mx);
          sq_y <= 14'(my) * 14'(my);
        end
        // numerator with half the divisor added for round half up
        BK_MUL2: begin
          num_x <= (NW'(sq_x) * NW'(step_x) << SH) + NW'(Den / 2);
          num_y <= (NW'(sq_y) * NW'(step_y) << SH) + NW'(Den / 2);
        end
        // reciprocal multiply for the constant divide by 127*127 shifted left by SR
        BK_DIV: begin
          q_x <= RW'((NW+RW)'(num_x) * (NW+RW)'(RECIP) >> NW);
          q_y <= RW'((NW+RW)'(num_y) * (NW+RW)'(RECIP) >> NW);
        end
        BK_FIX: begin
          q_x <= q_x + RW'(fix_x);
          q_y <= q_y + RW'(fix_y);
        end
        BK_MOVE: begin
          if (dx != '0 || dy != '0) begin
            mv <= 1'b1;
            pos_x <= cx;
            pos_y <= cy;
          end
        end
        BK_OUT: if (!out_valid || out_ready) begin
          out_valid <= 1'b1;
          out_result.status <= wk.kind;
          out_result.held_mask <= wk.held;
          out_result.pressed_mask <= wk.pressed;
          out_result.released_mask <= wk.released;
          out_result.axis_left_x <= wk.ax0;
          out_result.axis_left_y <= wk.ax1;
          out_result.axis_right_x <= wk.ax2;
          out_result.axis_right_y <= wk.ax3;
          out_result.cursor_x <= pos_x[PW-1:POS_FRAC_BITS];
          out_result.cursor_y <= pos_y[PW-1:POS_FRAC_BITS];
          out_result.moved <= mv;
          out_result.calibrated <= wk.calibrated;
        end
        default: ;
      endcase
    end
  end

  `include "gamepad_cursor_controller_macros.svh"
  `GCC_ASSERT_IMPL(a_ready_idle, in_ready, state == BK_IDLE)
  `GCC_ASSERT_NEXT(a_result_hold, out_valid && !out_ready, $stable(out_result))
  `GCC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

endmodule

### hw/rtl/gamepad_cursor_controller.sv
// ----------------------------------------------------------------------------
// gamepad_cursor_controller
// gamepad poll conditioning and fixed-point cursor, queue-style ports
// ----------------------------------------------------------------------------
// one poll is one transaction in; each gives exactly one result transaction.
// the front stage classifies a poll and calibrates as it takes it, and holds one
// registered classified poll for the back stage. the back sequencer sets the
// rate: it takes no new poll until the last result is registered. a processed
// poll passes accept, two multiplies, the reciprocal divide estimate, its
// one-step fix-up, the move and the result register; an ignored or disconnected
// poll goes from accept straight to the result register. a result left waiting
// holds the back stage; full is high while the front holds a poll and the back
// stage is busy. configuration registers sit on the apb port at byte offsets
// 0..16; the user must write them only while no poll is in flight, unenforced.
module gamepad_cursor_controller
  import gcc_pkg::*;
#(
  parameter int CALIB_SAMPLES = 16,
  parameter int POS_FRAC_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  poll_t       poll,
  output logic        full,
  output logic        empty,
  input  logic        pop,
  output result_t     result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [10:0] screen_width, screen_height;
  logic [6:0]  deadzone_counts;
  logic [11:0] step_x, step_y;
  logic [2:0]  reg_idx;
  logic f_ready, q_valid, q_ready, r_valid;
  work_t q_work;

  assign pready = 1'b1;
  assign reg_idx = paddr[4:2];

  // register writes on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width <= 11'd640;
      screen_height <= 11'd448;
      deadzone_counts <= 7'd23;
      step_x <= 12'd768;
      step_y <= 12'd717;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_WIDTH:  screen_width <= pwdata[10:0];
        REG_HEIGHT: screen_height <= pwdata[10:0];
        REG_DEAD:   deadzone_counts <= pwdata[6:0];
        REG_STEPX:  step_x <= pwdata[11:0];
        REG_STEPY:  step_y <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (reg_idx)
      REG_WIDTH:  prdata = {21'd0, screen_width};
      REG_HEIGHT: prdata = {21'd0, screen_height};
      REG_DEAD:   prdata = {25'd0, deadzone_counts};
      REG_STEPX:  prdata = {20'd0, step_x};
      REG_STEPY:  prdata = {20'd0, step_y};
      default:    prdata = '0;
    endcase
  end

  assign full = !f_ready;
  assign empty = !r_valid;

  gcc_front #(.CALIB_SAMPLES(CALIB_SAMPLES)) u_front (
    .clk, .rst,
    .in_valid(push), .in_poll(poll), .in_ready(f_ready),
    .deadzone(deadzone_counts),
    .out_valid(q_valid), .out_work(q_work), .out_ready(q_ready)
  );

  gcc_back #(.POS_FRAC_BITS(POS_FRAC_BITS)) u_back (
    .clk, .rst,
    .in_valid(q_valid), .in_work(q_work), .in_ready(q_ready),
    .screen_width, .screen_height, .step_x, .step_y,
    .out_valid(r_valid), .out_result(result), .out_ready(pop)
  );

endmodule
